>>> rtl/fixed_point_alu_with_exp_unit_macros.svh
`ifndef FIXED_POINT_ALU_WITH_EXP_UNIT_MACROS_SVH
`define FIXED_POINT_ALU_WITH_EXP_UNIT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define FPALU_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a condition holds in the cycle after a trigger.
`define FPALU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/fpalu_pkg.sv
package fpalu_pkg;

  localparam int DW        = 32;            // operand and result width
  localparam int QW        = 56;            // dividend magnitude: 32 bits shifted by up to 24
  localparam int FBW       = 5;             // fraction-bit register width
  localparam int CMD_W     = 3;
  localparam int RADIX_BITS = 4;            // quotient bits per divider stage
  localparam int DIV_STG   = QW / RADIX_BITS;
  localparam int EW        = 36;            // exp intermediate width

  localparam logic [FBW-1:0] FRAC_MIN = 5'd4;
  localparam logic [FBW-1:0] FRAC_MAX = 5'd24;
  localparam logic [FBW-1:0] FRAC_RST = 5'd10;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD = 3'd0,
    CMD_SUB = 3'd1,
    CMD_MUL = 3'd2,
    CMD_DIV = 3'd3,
    CMD_EXP = 3'd4
  } cmd_t;

  // One divider stage: partial remainder, dividend/quotient shift word and
  // the result of the non-divide operations riding along.
  typedef struct packed {
    logic          is_div;
    logic          neg;
    logic          bz;
    logic [DW-1:0] rem;
    logic [QW-1:0] dq;
    logic [DW-1:0] dvs;
    logic [DW-1:0] fres;
  } dstg_t;

  // Retire RADIX_BITS restoring-division steps.
  function automatic dstg_t div_step(input dstg_t s);
    dstg_t       t;
    logic [DW:0] r2;
    logic        ge;
    t = s;
    for (int i = 0; i < RADIX_BITS; i++) begin
      r2 = {t.rem, t.dq[QW-1]};
      ge = (r2 >= {1'b0, t.dvs});
      if (ge) begin
        r2 = r2 - {1'b0, t.dvs};
      end
      t.rem = r2[DW-1:0];
      t.dq  = {t.dq[QW-2:0], ge};
    end
    return t;
  endfunction

endpackage

>>> rtl/fixed_point_alu_with_exp_unit.sv
// Signed 32-bit fixed-point ALU: add, subtract, multiply, divide and a
// five-segment piecewise-linear exp, all sharing one format whose fraction
// bit count (4..24, reset 10, out-of-range writes clamp) is set through the
// cfg port; the user must write it only while the unit is idle, which the
// block does not enforce. Every operation flows through the same 17-stage
// pipeline: input register, operand stage (32x32 multiplier, add, exp
// segments, divide setup), fourteen divider stages retiring four quotient
// bits each out of a 56-bit dividend, and the output register. One beat is
// accepted per cycle unless stalled; all stages hold when the output
// register is full and out_tready is low. Divide truncates toward zero; a
// zero divisor returns 0 with div_by_zero set. Results wrap to 32 bits.
`include "fixed_point_alu_with_exp_unit_macros.svh"

module fixed_point_alu_with_exp_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [fpalu_pkg::FBW-1:0]     cfg_data,   // frac_bits
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [2*fpalu_pkg::DW-1:0]    in_tdata,   // operand_a, operand_b
  input  logic [fpalu_pkg::CMD_W-1:0]   in_tuser,   // cmd
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [fpalu_pkg::DW-1:0]      out_tdata,  // result
  output logic                          out_tuser   // div_by_zero
);
  import fpalu_pkg::*;

  logic [FBW-1:0] frac_r, frac_nxt;
  logic           en;

  // Input stage
  logic                 a_vld_r;
  cmd_t                 a_cmd_r;
  logic signed [DW-1:0] a_opa_r, a_opb_r;
  logic [FBW-1:0]       a_p_r;

  // Operand stage
  logic                   b_vld_r;
  logic                   b_mul_r;
  logic [FBW-1:0]         b_p_r;
  logic signed [2*DW-1:0] b_prod_r;
  dstg_t                  b_dst_r, b_dst_nxt;

  // Divider chain
  logic  [DIV_STG-1:0] dv_r;
  dstg_t               d_r [DIV_STG];
  dstg_t               d0_in;

  // Output stage
  logic          out_vld_r;
  logic [DW-1:0] out_res_r, out_res_nxt;
  logic          out_dz_r;

  // Exp segment math
  logic signed [EW-1:0] x, one, c3_8, c11_16, c3_4, three, two, half, qtr, eighth, sixt;
  logic signed [EW-1:0] e_val;
  logic [DW-1:0]        a_mag, b_mag, q;
  logic signed [2*DW-1:0] mul_sh;

  assign en        = !out_vld_r || out_tready;
  assign in_tready = en;
  assign cfg_ready = 1'b1;

  // Clamp the written fraction count into range.
  always_comb begin
    frac_nxt = frac_r;
    if (cfg_valid) begin
      if (cfg_data < FRAC_MIN) begin
        frac_nxt = FRAC_MIN;
      end else if (cfg_data > FRAC_MAX) begin
        frac_nxt = FRAC_MAX;
      end else begin
        frac_nxt = cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frac_r <= FRAC_RST;
    end else begin
      frac_r <= frac_nxt;
    end
  end

  // Operand stage logic: exp segments, add/sub, divide setup.
  always_comb begin
    x      = EW'(a_opa_r);
    one    = EW'(1) << a_p_r;
    c3_8   = EW'(3) << (a_p_r - 5'd3);
    c11_16 = EW'(11) << (a_p_r - 5'd4);
    c3_4   = EW'(3) << (a_p_r - 5'd2);
    three  = EW'(3) << a_p_r;
    two    = EW'(2) << a_p_r;
    half   = EW'(1) << (a_p_r - 5'd1);
    qtr    = EW'(1) << (a_p_r - 5'd2);
    eighth = EW'(1) << (a_p_r - 5'd3);
    sixt   = EW'(1) << (a_p_r - 5'd4);
    if (x >= c3_8) begin
      e_val = two + ((x - c11_16) <<< 1);
    end else if (x >= -c3_8) begin
      e_val = one + x;
    end else if (x >= -one) begin
      e_val = half + ((x + c11_16) >>> 1);
    end else if (x >= -one - c3_4) begin
      e_val = qtr + ((x + one + c3_8) >>> 2);
    end else if (x >= -three) begin
      e_val = eighth + ((x + two + sixt) >>> 3);
    end else begin
      e_val = '0;
    end

    a_mag = a_opa_r[DW-1] ? DW'(-a_opa_r) : DW'(a_opa_r);
    b_mag = a_opb_r[DW-1] ? DW'(-a_opb_r) : DW'(a_opb_r);

    b_dst_nxt        = '0;
    b_dst_nxt.is_div = (a_cmd_r == CMD_DIV);
    b_dst_nxt.neg    = a_opa_r[DW-1] ^ a_opb_r[DW-1];
    b_dst_nxt.bz     = (a_opb_r == '0);
    b_dst_nxt.dq     = QW'(a_mag) << a_p_r;
    b_dst_nxt.dvs    = b_mag;
    case (a_cmd_r)
      CMD_ADD: b_dst_nxt.fres = DW'(a_opa_r + a_opb_r);
      CMD_SUB: b_dst_nxt.fres = DW'(a_opa_r - a_opb_r);
      CMD_EXP: b_dst_nxt.fres = e_val[DW-1:0];
      default: b_dst_nxt.fres = '0;
    endcase
  end

  // First divider stage also finishes the multiply shift.
  always_comb begin
    mul_sh = b_prod_r >>> b_p_r;
    d0_in  = b_dst_r;
    if (b_mul_r) begin
      d0_in.fres = mul_sh[DW-1:0];
    end
  end

  // Sign-correct the quotient and pick the final value.
  always_comb begin
    q = d_r[DIV_STG-1].dq[DW-1:0];
    if (!d_r[DIV_STG-1].is_div) begin
      out_res_nxt = d_r[DIV_STG-1].fres;
    end else if (d_r[DIV_STG-1].bz) begin
      out_res_nxt = '0;
    end else if (d_r[DIV_STG-1].neg) begin
      out_res_nxt = -q;
    end else begin
      out_res_nxt = q;
    end
  end

  // Valid bits: advance together, hold on stall.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r   <= 1'b0;
      b_vld_r   <= 1'b0;
      dv_r      <= '0;
      out_vld_r <= 1'b0;
    end else if (en) begin
      a_vld_r   <= in_tvalid;
      b_vld_r   <= a_vld_r;
      dv_r      <= {dv_r[DIV_STG-2:0], b_vld_r};
      out_vld_r <= dv_r[DIV_STG-1];
    end
  end

  // Payload: no reset, advance on enable.
  always_ff @(posedge clk) begin
    if (en) begin
      a_cmd_r  <= cmd_t'(in_tuser);
      a_opa_r  <= in_tdata[DW-1:0];
      a_opb_r  <= in_tdata[2*DW-1:DW];
      a_p_r    <= frac_r;
      b_mul_r  <= (a_cmd_r == CMD_MUL);
      b_p_r    <= a_p_r;
      b_prod_r <= a_opa_r * a_opb_r;
      b_dst_r  <= b_dst_nxt;
      d_r[0]   <= div_step(d0_in);
      for (int i = 1; i < DIV_STG; i++) begin
        d_r[i] <= div_step(d_r[i-1]);
      end
      out_res_r <= out_res_nxt;
      out_dz_r  <= d_r[DIV_STG-1].is_div & d_r[DIV_STG-1].bz;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_res_r;
  assign out_tuser  = out_dz_r;

  `FPALU_ASSERT(a_frac_range, (frac_r >= FRAC_MIN) && (frac_r <= FRAC_MAX), "frac_bits out of range")
  `FPALU_ASSERT(a_dz_zero, !(out_vld_r && out_dz_r) || (out_res_r == '0), "div_by_zero with nonzero result")
  `FPALU_ASSERT_NEXT(a_stall_hold, !en, $stable(dv_r) && $stable(b_vld_r) && $stable(a_vld_r), "pipeline moved during stall")
  `FPALU_ASSERT_NEXT(a_drain, dv_r[DIV_STG-1] && en, out_vld_r, "divider result lost")

endmodule

>>> bench/tb_fixed_point_alu_with_exp_unit.sv
`timescale 1ns / 100ps

module tb_fixed_point_alu_with_exp_unit;
  import fpalu_pkg::*;

  localparam int PIPE_DEPTH = 17;
  localparam int CYCLE_LIMIT = 400000;
  localparam int LONG_HOLD = 200;

  logic clk;
  logic rst_n;
  logic cfg_valid;
  logic cfg_ready;
  logic [FBW-1:0] cfg_data;
  logic in_tvalid;
  logic in_tready;
  logic [2*DW-1:0] in_tdata;
  logic [CMD_W-1:0] in_tuser;
  logic out_tvalid;
  logic out_tready;
  logic [DW-1:0] out_tdata;
  logic out_tuser;

  typedef struct packed {
    logic [DW-1:0] value;
    logic          zero_div;
  } alu_res_t;

  alu_res_t result_queue[$];
  logic [FBW-1:0] frac_cur;
  int  mismatch_count;
  int  cycle_count;
  int  hold_cycles;
  bit  hold_off_long;

  fixed_point_alu_with_exp_unit dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata),   // operand_a, operand_b
    .in_tuser(in_tuser),   // cmd
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), // result
    .out_tuser(out_tuser)  // div_by_zero
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Arithmetic right shift of an exact product, floor semantics.
  function automatic longint scale_down(longint v, int unsigned s);
    return v >>> s;
  endfunction

  // Piecewise-linear e^x in the current format.
  function automatic longint exp_segment(longint x, int unsigned p);
    longint one, c38, c1116;
    one = longint'(1) << p;
    c38 = longint'(3) << (p - 3);
    c1116 = longint'(11) << (p - 4);
    if (x >= c38)
      return (longint'(2) << p) + scale_down((longint'(2) << p) * (x - c1116), p);
    if (x >= -c38)
      return one + x;
    if (x >= -one)
      return (longint'(1) << (p - 1)) +
             scale_down((longint'(1) << (p - 1)) * (x + c1116), p);
    if (x >= -one - (longint'(3) << (p - 2)))
      return (longint'(1) << (p - 2)) +
             scale_down((longint'(1) << (p - 2)) * (x + one + c38), p);
    if (x >= -(longint'(3) << p))
      return (longint'(1) << (p - 3)) + scale_down((longint'(1) << (p - 3)) *
             (x + (longint'(2) << p) + (longint'(1) << (p - 4))), p);
    return 0;
  endfunction

  function automatic alu_res_t alu_predict(logic [CMD_W-1:0] op, logic [DW-1:0] a_raw,
                                           logic [DW-1:0] b_raw);
    alu_res_t res;
    longint a, b, r;
    a = longint'($signed(a_raw));
    b = longint'($signed(b_raw));
    r = 0;
    res.zero_div = 1'b0;
    case (op)
      CMD_ADD: r = a + b;
      CMD_SUB: r = a - b;
      CMD_MUL: r = scale_down(a * b, frac_cur);
      CMD_DIV: begin
        if (b == 0) res.zero_div = 1'b1;
        else r = (a * (longint'(1) << frac_cur)) / b;
      end
      CMD_EXP: r = exp_segment(a, frac_cur);
      default: r = 0;
    endcase
    res.value = r[DW-1:0];
    return res;
  endfunction

  // Drive one beat and wait for its handshake; record the expected result.
  task automatic send_beat(logic [CMD_W-1:0] op, logic [DW-1:0] a, logic [DW-1:0] b);
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {b, a};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    result_queue.push_back(alu_predict(op, a, b));
  endtask

  // Drop valid for a random gap between bursts.
  task automatic sender_gap();
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (result_queue.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 4) @(posedge clk);
  endtask

  task automatic write_frac(logic [FBW-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    frac_cur = (v < FRAC_MIN) ? FRAC_MIN : (v > FRAC_MAX) ? FRAC_MAX : v;
  endtask

  function automatic logic [DW-1:0] rand_operand();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return DW'($signed($urandom_range(0, 4096)) - 2048);
      2: return DW'($signed($urandom_range(0, 1 << (frac_cur + 2)))
                 - $signed(1 << (frac_cur + 1)));
      3: return {$urandom_range(0, 1) ? 1'b1 : 1'b0, {(DW-1){1'b0}}} | $urandom_range(0, 1);
      4: return -$urandom_range(0, 4 << frac_cur);
      default: return $urandom_range(0, 1 << (frac_cur + 3));
    endcase
  endfunction

  // Extremes, every command, zero divisor, unknown commands, exp segments.
  task automatic test_directed();
    send_beat(CMD_ADD, 32'h7fff_ffff, 32'h0000_0001);
    send_beat(CMD_SUB, 32'h8000_0000, 32'h0000_0001);
    send_beat(CMD_MUL, 32'h7fff_ffff, 32'h7fff_ffff);
    send_beat(CMD_MUL, 32'h8000_0000, 32'h8000_0000);
    send_beat(CMD_MUL, 32'hffff_ffff, 32'h0000_0001);
    send_beat(CMD_DIV, 32'h1234_5678, 32'h0);
    send_beat(CMD_DIV, 32'h8000_0000, 32'hffff_ffff);
    send_beat(CMD_DIV, 32'h7fff_ffff, 32'h0000_0001);
    send_beat(CMD_DIV, -32'sd7, 32'd2);
    send_beat(3'd5, 32'h1, 32'h2);
    send_beat(3'd6, 32'hffff_ffff, 32'hffff_ffff);
    send_beat(3'd7, 32'h0, 32'h0);
    send_beat(CMD_EXP, 32'h7fff_ffff, 32'h0);
    send_beat(CMD_EXP, 32'h8000_0000, 32'hffff_ffff);
    send_beat(CMD_EXP, 32'h3 << (frac_cur - 3), 32'h0);
    send_beat(CMD_EXP, -(32'h3 << (frac_cur - 3)), 32'h0);
    send_beat(CMD_EXP, -(32'h1 << frac_cur), 32'h0);
    send_beat(CMD_EXP, -(32'h7 << (frac_cur - 2)), 32'h0);
    send_beat(CMD_EXP, -(32'h3 << frac_cur), 32'h0);
    send_beat(CMD_EXP, -(32'h3 << frac_cur) - 1, 32'h0);
    drain_results();
  endtask

  task automatic test_random(int count);
    for (int i = 0; i < count; i++) begin
      send_beat($urandom_range(0, 9) == 0 ? $urandom_range(5, 7) : $urandom_range(0, 4),
                rand_operand(), ($urandom_range(0, 15) == 0) ? '0 : rand_operand());
      sender_gap();
    end
    drain_results();
  endtask

  // Stall the output long enough to fill the pipeline, keep offering beats.
  task automatic test_backpressure();
    hold_off_long = 1'b1;
    for (int i = 0; i < 60; i++)
      send_beat($urandom_range(0, 4), $urandom(), $urandom());
    hold_off_long = 1'b0;
    drain_results();
  endtask

  initial begin
    logic [FBW-1:0] settings[6];
    settings = '{5'd0, 5'd4, 5'd31, 5'd24, 5'd16, 5'd7};
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    frac_cur = FRAC_RST;
    mismatch_count = 0;
    hold_off_long = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(250);
    foreach (settings[i]) begin
      write_frac(settings[i]);
      test_directed();
      test_random(200);
    end
    test_backpressure();
    if (mismatch_count == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  // Receiver stall pattern; on request hold off until hold_cycles reaches LONG_HOLD, then resume.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      hold_cycles <= 0;
    end else if (hold_off_long && hold_cycles < LONG_HOLD) begin
      out_tready <= 1'b0;
      hold_cycles <= hold_cycles + 1;
    end else begin
      if (!hold_off_long)
        hold_cycles <= 0;
      out_tready <= (cycle_count % 97 < 40) ? 1'b1 : ($urandom_range(0, 3) != 0);
    end
  end

  // Compare each accepted result beat with the oldest expectation.
  always @(posedge clk) begin
    alu_res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (result_queue.size() == 0) begin
        $display("%0t: unexpected result %h/%b", $time, out_tdata, out_tuser);
        mismatch_count++;
      end else begin
        want = result_queue.pop_front();
        if (want.value !== out_tdata || want.zero_div !== out_tuser) begin
          $display("%0t: expected %h/%b actual %h/%b", $time, want.value, want.zero_div,
                   out_tdata, out_tuser);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial cycle_count = 0;

endmodule
